// File: rtl/rars_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_pkg
// Shared types and constants for the range add / range sum core.
// ----------------------------------------------------------------------------
package rars_pkg;

  localparam int VAL_W   = 24;   // add amount width
  localparam int SUM_W   = 64;   // counter / sum width
  localparam int CFG_W   = 11;   // size register width
  localparam int POS_W   = 11;   // position field width
  localparam logic [CFG_W-1:0] SIZE_RST = 11'd1024;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // back end status seen by the front end
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// File: rtl/rars_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rars_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         full,
  output logic         not_empty
);

  logic [W-1:0] slot_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  assign head      = slot_r[rp_r];
  assign full      = cnt_r[1];
  assign not_empty = (cnt_r != 2'd0);

endmodule

// File: rtl/rars_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_front
// Size register, range clipping and command classification.
// ----------------------------------------------------------------------------
module rars_front #(
  parameter int SIZE  = 1024,
  parameter int IDX_W = 11,
  parameter int CMD_W = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rars_pkg::CFG_W-1:0]    cfg_size_in_use,
  input  logic                          accept,
  input  logic                          in_operation,
  input  logic [rars_pkg::POS_W-1:0]    in_range_first,
  input  logic [rars_pkg::POS_W-1:0]    in_range_last,
  input  logic [rars_pkg::VAL_W-1:0]    in_add_value,
  input  rars_pkg::back_stat_t          stat,
  output logic                          push,
  output logic [CMD_W-1:0]              cmd,
  output logic                          clr_req,
  output logic [IDX_W-1:0]              n_used
);

  localparam int CW = (IDX_W > rars_pkg::CFG_W) ? IDX_W : rars_pkg::CFG_W;

  logic [rars_pkg::CFG_W-1:0] size_r, size_nxt;
  logic                       clr_pend_r, clr_pend_nxt;
  logic [CW-1:0]              n_c, f_c, l_c;
  logic                       empty;

  always_comb begin
    size_nxt     = cfg_we ? cfg_size_in_use : size_r;
    clr_pend_nxt = cfg_we | (clr_pend_r & ~stat.clearing);

    n_c = CW'(size_r);
    if (n_c == '0) n_c = CW'(1);
    else if (n_c > CW'(SIZE)) n_c = CW'(SIZE);

    f_c = CW'(in_range_first);
    if (f_c == '0) f_c = CW'(1);
    l_c = CW'(in_range_last);
    if (l_c > n_c) l_c = n_c;
    empty = (f_c > l_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= rars_pkg::SIZE_RST;
      clr_pend_r <= 1'b0;
    end else begin
      size_r     <= size_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

  // an empty add has no effect and is dropped here
  assign push    = accept & ~((in_operation == rars_pkg::OP_ADD) & empty);
  assign cmd     = {in_operation, empty, f_c[IDX_W-1:0], l_c[IDX_W-1:0], in_add_value};
  assign clr_req = clr_pend_r;
  assign n_used  = n_c[IDX_W-1:0];

endmodule

// File: rtl/rars_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_back
// Executes commands on two Fenwick trees held in one memory.
// ----------------------------------------------------------------------------
module rars_back #(
  parameter int SIZE  = 1024,
  parameter int IDX_W = 11,
  parameter int CMD_W = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr_req,
  input  logic [IDX_W-1:0]            n_used,
  input  logic                        cmd_valid,
  input  logic [CMD_W-1:0]            cmd,
  output logic                        cmd_pop,
  output rars_pkg::back_stat_t        stat,
  output logic                        out_valid,
  output logic [rars_pkg::SUM_W-1:0]  out_range_sum
);

  localparam int AW = $clog2(SIZE + 1);
  localparam int SW = rars_pkg::SUM_W;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SETUP = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_WR    = 4'd4;
  localparam logic [3:0] ST_QRD   = 4'd5;
  localparam logic [3:0] ST_QACC  = 4'd6;
  localparam logic [3:0] ST_QMUL  = 4'd7;
  localparam logic [3:0] ST_QSUB  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [2*SW-1:0] mem [SIZE+1];
  logic [2*SW-1:0] rd_q;
  logic            we;
  logic [AW-1:0]   wa;
  logic [2*SW-1:0] wd;

  logic [3:0]       st_r, st_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [rars_pkg::VAL_W-1:0] v_r, v_nxt;
  logic             pass_r, pass_nxt;
  logic [SW-1:0]    d1_r, d1_nxt, d2_r, d2_nxt;
  logic [SW-1:0]    mlo_r, mlo_nxt, mhi_r, mhi_nxt;
  logic [SW-1:0]    s1_r, s1_nxt, s2_r, s2_nxt;
  logic [SW-1:0]    prod_r, prod_nxt, res_r, res_nxt;

  logic             c_query, c_empty;
  logic [IDX_W-1:0] c_first, c_last, low_bit, lo_m1;
  logic [rars_pkg::VAL_W-1:0] c_val;
  logic [IDX_W:0]   up_idx, hi_p1;
  logic [SW-1:0]    prefix;

  assign {c_query, c_empty, c_first, c_last, c_val} = cmd;

  always_comb begin
    st_nxt   = st_r;
    clr_nxt  = clr_r;
    idx_nxt  = idx_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    v_nxt    = v_r;
    pass_nxt = pass_r;
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    mlo_nxt  = mlo_r;
    mhi_nxt  = mhi_r;
    s1_nxt   = s1_r;
    s2_nxt   = s2_r;
    prod_nxt = prod_r;
    res_nxt  = res_r;
    cmd_pop  = 1'b0;
    we       = 1'b0;
    wa       = idx_r[AW-1:0];
    wd       = {rd_q[2*SW-1:SW] + d1_r, rd_q[SW-1:0] + d2_r};
    low_bit  = idx_r & (~idx_r + 1'b1);
    up_idx   = {1'b0, idx_r} + {1'b0, low_bit};
    hi_p1    = {1'b0, hi_r} + 1'b1;
    lo_m1    = lo_r - 1'b1;
    prefix   = prod_r - s2_r;

    unique case (st_r)
      ST_CLR: begin
        we = 1'b1;
        wa = clr_r;
        wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(SIZE)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          lo_nxt  = c_first;
          hi_nxt  = c_last;
          v_nxt   = c_val;
          pass_nxt = 1'b0;
          if (c_query == rars_pkg::OP_QUERY) begin
            if (c_empty) begin
              res_nxt = '0;
              st_nxt  = ST_OUT;
            end else begin
              idx_nxt = c_last;
              s1_nxt  = '0;
              s2_nxt  = '0;
              st_nxt  = ST_QRD;
            end
          end else begin
            st_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        mlo_nxt = SW'(v_r) * SW'(lo_m1);
        mhi_nxt = SW'(v_r) * SW'(hi_r);
        idx_nxt = lo_r;
        st_nxt  = ST_RD;
        d1_nxt  = SW'(v_r);
      end
      ST_RD: begin
        if (!pass_r) d2_nxt = mlo_r;
        st_nxt = ST_WR;
      end
      ST_WR: begin
        we = 1'b1;
        if (up_idx <= {1'b0, n_used}) begin
          idx_nxt = up_idx[IDX_W-1:0];
          st_nxt  = ST_RD;
        end else if (!pass_r && (hi_p1 <= {1'b0, n_used})) begin
          // second walk removes the amount past the end of the range
          pass_nxt = 1'b1;
          idx_nxt  = hi_p1[IDX_W-1:0];
          d1_nxt   = '0 - SW'(v_r);
          d2_nxt   = '0 - mhi_r;
          st_nxt   = ST_RD;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_QRD: begin
        st_nxt = ST_QACC;
      end
      ST_QACC: begin
        s1_nxt  = s1_r + rd_q[2*SW-1:SW];
        s2_nxt  = s2_r + rd_q[SW-1:0];
        idx_nxt = idx_r - low_bit;
        st_nxt  = (idx_r == low_bit) ? ST_QMUL : ST_QRD;
      end
      ST_QMUL: begin
        prod_nxt = s1_r * SW'(pass_r ? lo_m1 : hi_r);
        st_nxt   = ST_QSUB;
      end
      ST_QSUB: begin
        if (pass_r) begin
          res_nxt = res_r - prefix;
          st_nxt  = ST_OUT;
        end else begin
          res_nxt = prefix;
          if (lo_m1 == '0) begin
            st_nxt = ST_OUT;
          end else begin
            pass_nxt = 1'b1;
            idx_nxt  = lo_m1;
            s1_nxt   = '0;
            s2_nxt   = '0;
            st_nxt   = ST_QRD;
          end
        end
      end
      ST_OUT: begin
        st_nxt = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (clr_req) begin
      st_nxt  = ST_CLR;
      clr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLR;
      clr_r <= '0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    v_r    <= v_nxt;
    pass_r <= pass_nxt;
    d1_r   <= d1_nxt;
    d2_r   <= d2_nxt;
    mlo_r  <= mlo_nxt;
    mhi_r  <= mhi_nxt;
    s1_r   <= s1_nxt;
    s2_r   <= s2_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[idx_r[AW-1:0]];
  end

  assign stat.clearing = (st_r == ST_CLR);
  assign out_valid     = (st_r == ST_OUT);
  assign out_range_sum = res_r;

endmodule

// File: rtl/range_add_range_sum_tree_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_core
// Range add / range sum store over SIZE 64-bit counters.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Adds change the
// store and return nothing; queries return one sum on out_range_sum, marked by
// out_valid for one cycle, and the receiver has no way to stall it. The
// counters live in two Fenwick trees packed in one memory of SIZE+1 words, and
// every tree step is a read then a write (or accumulate) of that single port:
// an add makes up to two upward walks; a query makes two downward walks, each
// followed by a multiply and a subtract, or one such walk when first is 1;
// a query over an empty range returns zero without a walk. A two-entry queue
// lets up to two transactions wait behind the one in work. After reset and
// after any write of cfg_size_in_use, the store is zeroed word by word over
// all SIZE+1 words, during which busy stays high.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_core #(
  parameter int SIZE = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [10:0]                cfg_size_in_use,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_operation,
  input  logic [10:0]                in_range_first,
  input  logic [10:0]                in_range_last,
  input  logic [23:0]                in_add_value,
  output logic                       out_valid,
  output logic [63:0]                out_range_sum
);

  localparam int IDX_W = $clog2(SIZE + 2);
  localparam int CMD_W = 2 + 2 * IDX_W + rars_pkg::VAL_W;

  rars_pkg::back_stat_t stat;
  logic             accept, push, pop, q_full, q_valid, clr_req;
  logic [CMD_W-1:0] cmd_in, cmd_head;
  logic [IDX_W-1:0] n_used;

  // no transaction while a clear is pending or running
  assign busy   = q_full | stat.clearing | clr_req;
  assign accept = start & ~busy;

  rars_front #(.SIZE(SIZE), .IDX_W(IDX_W), .CMD_W(CMD_W)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_size_in_use (cfg_size_in_use),
    .accept          (accept),
    .in_operation    (in_operation),
    .in_range_first  (in_range_first),
    .in_range_last   (in_range_last),
    .in_add_value    (in_add_value),
    .stat            (stat),
    .push            (push),
    .cmd             (cmd_in),
    .clr_req         (clr_req),
    .n_used          (n_used)
  );

  rars_queue #(.W(CMD_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd_in),
    .pop       (pop),
    .head      (cmd_head),
    .full      (q_full),
    .not_empty (q_valid)
  );

  rars_back #(.SIZE(SIZE), .IDX_W(IDX_W), .CMD_W(CMD_W)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .clr_req       (clr_req),
    .n_used        (n_used),
    .cmd_valid     (q_valid),
    .cmd           (cmd_head),
    .cmd_pop       (pop),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_range_sum (out_range_sum)
  );

  // results are single-cycle pulses
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // no result while the store is being cleared
  a_no_out_clr: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !out_valid) else $error("result during clear");

  // a size write blocks new transactions on the next cycle
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy) else $error("size write did not raise busy");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for range_add_range_sum_tree_core: random and directed
// range adds and range sum queries, checked against a flat counter array.
// ----------------------------------------------------------------------------

// Keeps a flat copy of the counters and the queue of sums still owed.
class range_sum_board;
  bit [63:0] counters[1024];
  bit [63:0] sums_owed[$];
  int unsigned used_n;
  int unsigned errors;

  function new();
    resize(11'd1024);
    errors = 0;
  endfunction

  // Any size write clears the store; 0 acts as 1, above 1024 as 1024.
  function void resize(bit [10:0] n);
    used_n = (n == 0) ? 1 : ((n > 1024) ? 1024 : n);
    foreach (counters[i]) counters[i] = '0;
  endfunction

  // Called for every accepted transaction.
  function void note_transaction(bit op, bit [10:0] first, bit [10:0] last,
                                 bit [23:0] amount);
    int unsigned lo;
    int unsigned hi;
    bit [63:0] acc;
    lo = (first == 0) ? 1 : first;
    hi = (last > used_n) ? used_n : last;
    acc = '0;
    for (int unsigned p = lo; p <= hi; p++) begin
      if (op == rars_pkg::OP_ADD) counters[p-1] += 64'(amount);
      else acc += counters[p-1];
    end
    if (op == rars_pkg::OP_QUERY) sums_owed = {sums_owed, acc};
  endfunction

  function void check_sum(bit [63:0] actual);
    bit [63:0] want;
    if (sums_owed.size() == 0) begin
      $display("%0t: unexpected sum, expected none, actual %h", $time, actual);
      errors++;
      return;
    end
    want = sums_owed.pop_front();
    if (want !== actual) begin
      $display("%0t: range_sum mismatch, expected %h, actual %h",
               $time, want, actual);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;   // an add can still be in work

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_size_in_use = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_operation = 1'b0;
  logic [10:0] in_range_first = '0;
  logic [10:0] in_range_last = '0;
  logic [23:0] in_add_value = '0;
  logic        out_valid;
  logic [63:0] out_range_sum;

  range_sum_board board = new();
  int unsigned cycles = 0;
  int unsigned cur_n = 1024;

  range_add_range_sum_tree_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_size_in_use (cfg_size_in_use),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_range_first  (in_range_first),
    .in_range_last   (in_range_last),
    .in_add_value    (in_add_value),
    .out_valid       (out_valid),
    .out_range_sum   (out_range_sum)
  );

  always #5 clk = ~clk;

  // Results cannot be stalled: every strobe is checked on the spot.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_sum(out_range_sum);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("range_add_range_sum_tree_core verification failed");
      $finish;
    end
  end

  // Hold start until the core takes the transaction, log it, then drop start.
  task automatic send(bit op, bit [10:0] first, bit [10:0] last, bit [23:0] amount);
    @(negedge clk);
    in_operation   = op;
    in_range_first = first;
    in_range_last  = last;
    in_add_value   = amount;
    start          = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    board.note_transaction(op, first, last, amount);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Idle gap, mostly short, sometimes long; inputs wiggle while start is low.
  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) < 5) ? 0 :
        (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60));
    repeat (n) begin
      @(negedge clk);
      start          = 1'b0;
      in_operation   = 1'($urandom());
      in_range_first = 11'($urandom());
      in_range_last  = 11'($urandom());
      in_add_value   = 24'($urandom());
    end
  endtask

  // Size writes only once nothing is owed and any add has had time to finish.
  task automatic set_size(bit [10:0] n);
    while (board.sums_owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    start           = 1'b0;
    cfg_we          = 1'b1;
    cfg_size_in_use = n;
    @(negedge clk);
    cfg_we = 1'b0;
    board.resize(n);
    cur_n = board.used_n;
  endtask

  task automatic random_item();
    bit [10:0] f;
    bit [10:0] l;
    if ($urandom_range(0, 9) == 0) begin
      f = 11'($urandom());      // full 11-bit noise, mostly clipped or empty
      l = 11'($urandom());
    end else begin
      f = 11'($urandom_range(0, cur_n + 2));
      l = 11'($urandom_range(f, cur_n + 2));
      if ($urandom_range(0, 15) == 0) l = 11'($urandom_range(0, cur_n));
    end
    send(1'($urandom_range(0, 1)), f, l,
         ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom()));
    idle_gap();
  endtask

  initial begin
    bit [10:0] sizes[7] = '{11'd8, 11'd1, 11'd0, 11'd2047, 11'd37, 11'd1024, 11'd300};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset size, extremes, clipping and empty ranges
    send(rars_pkg::OP_QUERY, 11'd1, 11'd1024, 24'd0);
    send(rars_pkg::OP_ADD,   11'd0, 11'd2047, 24'hFFFFFF);
    send(rars_pkg::OP_QUERY, 11'd1, 11'd1024, 24'd0);
    send(rars_pkg::OP_ADD,   11'd1024, 11'd1024, 24'd5);
    send(rars_pkg::OP_QUERY, 11'd1024, 11'd2047, 24'd0);
    send(rars_pkg::OP_ADD,   11'd10, 11'd3, 24'd7);
    send(rars_pkg::OP_QUERY, 11'd10, 11'd3, 24'hFFFFFF);
    send(rars_pkg::OP_QUERY, 11'd0, 11'd0, 24'd0);
    send(rars_pkg::OP_ADD,   11'd1, 11'd1, 24'd0);
    send(rars_pkg::OP_QUERY, 11'd1, 11'd1, 24'd0);
    send(rars_pkg::OP_ADD,   11'd1025, 11'd2047, 24'd9);
    send(rars_pkg::OP_QUERY, 11'd512, 11'd513, 24'd0);
    send(rars_pkg::OP_QUERY, 11'd2047, 11'd2047, 24'd0);

    // random phases across sizes, extremes included
    foreach (sizes[s]) begin
      set_size(sizes[s]);
      send(rars_pkg::OP_QUERY, 11'd1, 11'd2047, 24'd0);   // store must read back empty
      repeat (120) random_item();
    end

    @(negedge clk);
    start = 1'b0;
    while (board.sums_owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("range_add_range_sum_tree_core verification clean");
    end else begin
      $display("range_add_range_sum_tree_core verification failed");
    end
    $finish;
  end

endmodule
